/* hdl/trst_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package trst_pkg;
	localparam logic [2:0] REQ_TICK = 3'd0;
	localparam logic [2:0] REQ_STATUS = 3'd1;
	localparam logic [2:0] REQ_REPORT = 3'd2;
	localparam logic [2:0] REQ_STAT_FAIL = 3'd3;
	localparam logic [2:0] REQ_REP_FAIL = 3'd4;

	localparam logic [2:0] OUT_NO_DATA = 3'd0;
	localparam logic [2:0] OUT_BAD_COUNT = 3'd1;
	localparam logic [2:0] OUT_APPLIED = 3'd2;
	localparam logic [2:0] OUT_BAD_SUM = 3'd3;
	localparam logic [2:0] OUT_READ_FAIL = 3'd4;

	localparam logic [15:0] TIMEOUT_RESET = 16'd150;

	typedef struct packed {
		logic take;
		logic snap_start;
		logic [2:0] outcome;
		logic clr;
		logic apply_start;
	} trst_cmd_t;

	typedef struct packed {
		logic snap_busy;
		logic apply_busy;
	} trst_stat_t;
endpackage
`default_nettype wire

/* hdl/trst_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module trst_ctrl
	import trst_pkg::*;
#(
	parameter int MAX_POINTS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] req_type,
	input wire logic [7:0] data_byte,
	input wire logic [15:0] cfg_wdata,
	input wire logic cfg_we,
	input wire trst_stat_t stat,
	output trst_cmd_t cmd,
	output logic expire,
	output logic rec_we,
	output logic [3:0] rec_idx,
	output logic [2:0] rec_off,
	output logic [3:0] pts
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_APPLY = 3'b010,
		ST_SNAP = 3'b100
	} state_t;

	state_t state_q;
	logic [15:0] timeout_q, ticks_q;
	logic [7:0] sum_q;
	logic [6:0] pos_q;
	logic [3:0] pts_q;
	logic inrep_q, good_q;
	logic take, stale, last_byte, cnt_bad;
	logic [6:0] pm1, total;
	logic [7:0] sum_n;
	logic [2:0] oc_q;
	logic clr_q;

	assign take = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || stat.snap_busy;
	assign stale = good_q && (ticks_q >= timeout_q);
	assign expire = take && stale && (req_type == REQ_STAT_FAIL || req_type == REQ_REP_FAIL ||
		(req_type == REQ_REPORT && inrep_q && last_byte && sum_n != 8'd0));
	assign pm1 = pos_q - 7'd1;
	assign total = 7'd3 + {pts_q, 3'b000};
	assign last_byte = (pos_q + 7'd1) >= total;
	assign sum_n = sum_q + data_byte;
	assign cnt_bad = (data_byte[3:0] == 4'd0) || (data_byte[3:0] > 4'(MAX_POINTS));
	assign rec_idx = pm1[6:3];
	assign rec_off = pm1[2:0];
	assign rec_we = take && req_type == REQ_REPORT && inrep_q && pos_q != 7'd0 &&
		pm1[6:3] < pts_q;
	assign pts = pts_q;

	always_comb begin
		cmd = '0;
		cmd.take = take;
		cmd.outcome = oc_q;
		cmd.clr = clr_q;
		cmd.apply_start = (state_q == ST_APPLY) && !stat.apply_busy && oc_q == OUT_APPLIED
			&& clr_q;
		cmd.snap_start = (state_q == ST_SNAP) && !stat.snap_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			timeout_q <= TIMEOUT_RESET;
			ticks_q <= '0;
			sum_q <= '0;
			pos_q <= '0;
			pts_q <= '0;
			inrep_q <= 1'b0;
			good_q <= 1'b0;
			oc_q <= OUT_NO_DATA;
			clr_q <= 1'b0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (req_type) inside
							REQ_TICK: begin
								if (ticks_q != 16'hffff) ticks_q <= ticks_q + 16'd1;
							end
							REQ_STATUS: begin
								inrep_q <= 1'b0;
								pos_q <= '0;
								sum_q <= '0;
								if (!data_byte[7]) begin
									oc_q <= OUT_NO_DATA;
									clr_q <= 1'b0;
									state_q <= ST_SNAP;
								end else if (cnt_bad) begin
									oc_q <= OUT_BAD_COUNT;
									clr_q <= 1'b1;
									state_q <= ST_SNAP;
								end else begin
									pts_q <= data_byte[3:0];
									inrep_q <= 1'b1;
								end
							end
							REQ_REPORT: begin
								if (inrep_q) begin
									if (!last_byte) begin
										sum_q <= sum_n;
										pos_q <= pos_q + 7'd1;
									end else begin
										inrep_q <= 1'b0;
										pos_q <= '0;
										sum_q <= '0;
										clr_q <= 1'b1;
										if (sum_n == 8'd0) begin
											oc_q <= OUT_APPLIED;
											good_q <= 1'b1;
											ticks_q <= '0;
											state_q <= ST_APPLY;
										end else begin
											oc_q <= OUT_BAD_SUM;
											state_q <= ST_SNAP;
										end
									end
								end
							end
							REQ_STAT_FAIL, REQ_REP_FAIL: begin
								inrep_q <= 1'b0;
								pos_q <= '0;
								sum_q <= '0;
								oc_q <= OUT_READ_FAIL;
								clr_q <= 1'b0;
								state_q <= ST_SNAP;
							end
							default: ;
						endcase
					end
				end
				ST_APPLY: begin
					if (cmd.apply_start) clr_q <= 1'b0;
					else if (!stat.apply_busy && !clr_q) begin
						clr_q <= 1'b1;
						state_q <= ST_SNAP;
					end
				end
				ST_SNAP: begin
					if (cmd.snap_start) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/trst_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
module trst_dpath
	import trst_pkg::*;
#(
	parameter int SLOTS = 5,
	parameter int MAX_POINTS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire trst_cmd_t cmd,
	input wire logic [7:0] data_byte,
	input wire logic cnt_clear,
	input wire logic expire,
	input wire logic rec_we,
	input wire logic [3:0] rec_idx,
	input wire logic [2:0] rec_off,
	input wire logic [3:0] pts,
	output trst_stat_t stat,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] outcome,
	output logic clear_status,
	output logic [3:0] slot_index,
	output logic pressed,
	output logic [3:0] touch_id,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic last
);
	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [35:0] rec_mem [MAX_POINTS];
	logic [35:0] rec_rd_q;
	logic [SLOTS-1:0] prs_q, seen_q;
	logic [3:0] trk_q [SLOTS];
	logic [15:0] x_q [SLOTS];
	logic [15:0] y_q [SLOTS];
	logic [PW-1:0] rd_idx;
	logic [3:0] ap_cnt_q;
	logic ap_busy_q, ap_rd_q;
	logic [SW-1:0] snap_idx_q;
	logic snap_busy_q;
	logic [2:0] oc_q;
	logic clr_q;
	logic [SW-1:0] pick;
	logic pick_ok;
	logic [3:0] rid;

	assign rd_idx = ap_cnt_q[PW-1:0];
	assign rid = rec_rd_q[3:0];
	assign stat.apply_busy = ap_busy_q;
	assign stat.snap_busy = snap_busy_q;

	always_ff @(posedge clk) begin
		if (rec_we) begin
			case (rec_off)
				3'd0: rec_mem[rec_idx[PW-1:0]][3:0] <= data_byte[3:0];
				3'd1: rec_mem[rec_idx[PW-1:0]][11:4] <= data_byte;
				3'd2: rec_mem[rec_idx[PW-1:0]][19:12] <= data_byte;
				3'd3: rec_mem[rec_idx[PW-1:0]][27:20] <= data_byte;
				3'd4: rec_mem[rec_idx[PW-1:0]][35:28] <= data_byte;
				default: ;
			endcase
		end
		rec_rd_q <= rec_mem[rd_idx];
	end

	always_comb begin
		pick = '0;
		pick_ok = 1'b0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (!prs_q[s] && !seen_q[s]) begin
				pick = SW'(s);
				pick_ok = 1'b1;
			end
		end
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (prs_q[s] && !seen_q[s] && trk_q[s] == rid) begin
				pick = SW'(s);
				pick_ok = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prs_q <= '0;
			seen_q <= '0;
			for (int s = 0; s < SLOTS; s++) begin
				trk_q[s] <= '0;
				x_q[s] <= '0;
				y_q[s] <= '0;
			end
			ap_cnt_q <= '0;
			ap_busy_q <= 1'b0;
			ap_rd_q <= 1'b0;
		end else begin
			if (cnt_clear || expire) prs_q <= '0;
			if (cmd.apply_start) begin
				ap_busy_q <= 1'b1;
				ap_cnt_q <= '0;
				ap_rd_q <= 1'b0;
				seen_q <= '0;
			end else if (ap_busy_q) begin
				if (!ap_rd_q) begin
					if (ap_cnt_q >= pts) begin
						ap_busy_q <= 1'b0;
						prs_q <= prs_q & seen_q;
					end else ap_rd_q <= 1'b1;
				end else begin
					ap_rd_q <= 1'b0;
					ap_cnt_q <= ap_cnt_q + 4'd1;
					if (pick_ok) begin
						seen_q[pick] <= 1'b1;
						prs_q[pick] <= 1'b1;
						trk_q[pick] <= rid;
						x_q[pick] <= rec_rd_q[19:4];
						y_q[pick] <= rec_rd_q[35:20];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_busy_q <= 1'b0;
			snap_idx_q <= '0;
			out_valid <= 1'b0;
			oc_q <= OUT_NO_DATA;
			clr_q <= 1'b0;
		end else begin
			if (cmd.snap_start) begin
				snap_busy_q <= 1'b1;
				snap_idx_q <= '0;
				oc_q <= cmd.outcome;
				clr_q <= cmd.clr;
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				if (snap_idx_q == SW'(SLOTS - 1)) begin
					out_valid <= 1'b0;
					snap_busy_q <= 1'b0;
				end else snap_idx_q <= snap_idx_q + SW'(1);
			end
		end
	end

	assign outcome = oc_q;
	assign clear_status = clr_q;
	assign slot_index = 4'(snap_idx_q);
	assign pressed = prs_q[snap_idx_q];
	assign touch_id = trk_q[snap_idx_q];
	assign pos_x = x_q[snap_idx_q];
	assign pos_y = y_q[snap_idx_q];
	assign last = (snap_idx_q == SW'(SLOTS - 1));
endmodule
`default_nettype wire

/* hdl/touch_report_slot_tracker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Touch report parser and contact slot tracker. An item that yields a snapshot (status
// byte without a report, bad count, end of report, read failure) is followed by SLOTS
// result transactions, slot 0 first, one per cycle when not stalled; out_valid is
// registered once the controller reaches its snapshot state, and input is stalled until
// the last result is taken. At the end of a good report the slot search walks the stored
// records through one read port, reading each record and then applying it before the
// next, and the snapshot follows once the search is done.
module touch_report_slot_tracker_unit
	import trst_pkg::*;
#(
	parameter int SLOTS = 5,
	parameter int MAX_POINTS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [15:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] req_type,
	input wire logic [7:0] data_byte,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] outcome,
	output logic clear_status,
	output logic [3:0] slot_index,
	output logic pressed,
	output logic [3:0] touch_id,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic last
);
	trst_cmd_t cmd;
	trst_stat_t stat;
	logic expire, rec_we, cnt_clear;
	logic [3:0] rec_idx, pts;
	logic [2:0] rec_off;

	assign cnt_clear = cmd.take && req_type == REQ_STATUS && data_byte[7] &&
		(data_byte[3:0] == 4'd0 || data_byte[3:0] > 4'(MAX_POINTS));

	trst_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .data_byte(data_byte), .cfg_wdata(cfg_wdata),
		.cfg_we(cfg_we), .stat(stat), .cmd(cmd), .expire(expire), .rec_we(rec_we),
		.rec_idx(rec_idx), .rec_off(rec_off), .pts(pts)
	);

	trst_dpath #(.SLOTS(SLOTS), .MAX_POINTS(MAX_POINTS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.data_byte(data_byte), .cnt_clear(cnt_clear), .expire(expire),
		.rec_we(rec_we), .rec_idx(rec_idx), .rec_off(rec_off), .pts(pts),
		.stat(stat), .out_valid(out_valid), .out_stall(out_stall), .outcome(outcome),
		.clear_status(clear_status), .slot_index(slot_index), .pressed(pressed),
		.touch_id(touch_id), .pos_x(pos_x), .pos_y(pos_y), .last(last)
	);
endmodule
`default_nettype wire
